>>> rtl/core/polygon_rect_clipper_macros.svh
// Assertion shorthands shared by the clipper RTL.
`ifndef POLYGON_RECT_CLIPPER_MACROS_SVH
`define POLYGON_RECT_CLIPPER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("clipper check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("clipper check failed");

`endif

>>> rtl/core/prc_pkg.sv
package prc_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] REG_X_MIN = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_X_MAX = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_Y_MIN = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_Y_MAX = 3'd3;

	// Window reset values.
	localparam int WIN_RESET_LOW  = 50;
	localparam int WIN_RESET_HIGH = 200;

	// Four boundaries in the order left, top, right, bottom.
	localparam int NUM_SIDES = 4;
	// Side tests y instead of x.
	localparam logic [NUM_SIDES-1:0] SIDE_USE_Y = 4'b1010;
	// Side is inside at or below its bound instead of at or above.
	localparam logic [NUM_SIDES-1:0] SIDE_UPPER = 4'b1100;

	// Control half of the vertex link between neighboring cells.
	typedef struct packed {
		logic valid;
		logic end_mark;
	} link_ctl_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_EDGE,
		CS_MUL,
		CS_DIV,
		CS_FIX,
		CS_EMIT,
		CS_NEXT,
		CS_END
	} cell_state_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FEED_RD,
		ST_FEED_SEND,
		ST_FEED_END,
		ST_WAIT,
		ST_OUT_RD,
		ST_OUT_SHOW,
		ST_OUT_EMPTY
	} top_state_t;

endpackage

>>> rtl/core/prc_cell.sv
module prc_cell import prc_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int MAX_OUT    = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         use_y,
	input  logic                         upper,
	input  logic signed [COORD_BITS-1:0] bound,
	input  link_ctl_t                    in_ctl,
	input  logic signed [COORD_BITS-1:0] in_x,
	input  logic signed [COORD_BITS-1:0] in_y,
	output logic                         in_ready,
	output link_ctl_t                    out_ctl,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y,
	input  logic                         out_ready,
	output logic                         drop
);

	localparam int DW    = COORD_BITS + 1;
	localparam int PW    = 2 * DW;
	localparam int BW    = COORD_BITS + 2;
	localparam int KW    = $clog2(PW + 1);
	localparam int CNT_W = $clog2(MAX_OUT + 1);

	cell_state_t state_q, state_d;

	logic                         have_first_q, end_pend_q, emit_cur_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         out_valid_q, out_end_q;
	logic signed [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, emit_x_q, emit_y_q;
	logic signed [COORD_BITS-1:0] out_x_q, out_y_q, o0_q;
	logic [PW-1:0]                div_q;
	logic [DW-1:0]                dmag_q, rem_q, quo_q;
	logic                         neg_q;
	logic [KW-1:0]                k_q;

	logic signed [COORD_BITS-1:0] p_a, p_o, c_a, c_o, fix_c;
	logic                         ip, iq, out_free, full, load_out;
	logic signed [DW-1:0]         num_w, off_w, den_w;
	logic [DW-1:0]                num_mag, off_mag, den_mag;
	logic [PW-1:0]                prod_w;
	logic [DW:0]                  trial, diff;
	logic                         ge;
	logic signed [BW-1:0]         base_w, fix_w, o0_ext, qs;

	// Coordinates along the tested axis (a) and the other axis (o).
	assign p_a = use_y ? prev_y_q : prev_x_q;
	assign p_o = use_y ? prev_x_q : prev_y_q;
	assign c_a = use_y ? cur_y_q : cur_x_q;
	assign c_o = use_y ? cur_x_q : cur_y_q;

	assign ip = upper ? (p_a <= bound) : (p_a >= bound);
	assign iq = upper ? (c_a <= bound) : (c_a >= bound);

	assign num_w   = DW'(c_o) - DW'(p_o);
	assign off_w   = DW'(bound) - DW'(p_a);
	assign den_w   = DW'(c_a) - DW'(p_a);
	assign num_mag = num_w[DW-1] ? DW'(-num_w) : DW'(num_w);
	assign off_mag = off_w[DW-1] ? DW'(-off_w) : DW'(off_w);
	assign den_mag = den_w[DW-1] ? DW'(-den_w) : DW'(den_w);
	assign prod_w  = num_mag * off_mag;

	// One restoring division step per cycle.
	assign trial = {rem_q, div_q[PW-1]};
	assign diff  = trial - {1'b0, dmag_q};
	assign ge    = trial >= {1'b0, dmag_q};

	// The crossing coordinate (start coordinate plus the exact quotient) is truncated toward zero.
	assign o0_ext = BW'(o0_q);
	assign qs     = $signed({1'b0, quo_q});
	always_comb begin
		base_w = neg_q ? (o0_ext - qs) : (o0_ext + qs);
		fix_w  = base_w;
		if (rem_q != '0) begin
			if (!neg_q && base_w[BW-1]) begin
				fix_w = base_w + BW'(1);
			end else if (neg_q && !base_w[BW-1] && base_w != '0) begin
				fix_w = base_w - BW'(1);
			end
		end
	end
	assign fix_c = fix_w[COORD_BITS-1:0];

	assign out_free = !out_valid_q || out_ready;
	assign full     = cnt_q == CNT_W'(MAX_OUT);
	assign in_ready = state_q == CS_IDLE;

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		drop     = 1'b0;
		unique case (state_q)
			CS_IDLE: begin
				if (in_ctl.valid) begin
					if (in_ctl.end_mark) begin
						state_d = have_first_q ? CS_EDGE : CS_END;
					end else if (have_first_q) begin
						state_d = CS_EDGE;
					end
				end
			end
			CS_EDGE: begin
				if (ip != iq) begin
					state_d = CS_MUL;
				end else if (ip) begin
					state_d = CS_EMIT;
				end else begin
					state_d = CS_NEXT;
				end
			end
			CS_MUL: state_d = CS_DIV;
			CS_DIV: begin
				if (k_q == KW'(1)) begin
					state_d = CS_FIX;
				end
			end
			CS_FIX: state_d = CS_EMIT;
			CS_EMIT: begin
				if (full || out_free) begin
					drop     = full;
					load_out = !full;
					if (!emit_cur_q) begin
						state_d = CS_NEXT;
					end
				end
			end
			CS_NEXT: state_d = end_pend_q ? CS_END : CS_IDLE;
			CS_END: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= CS_IDLE;
			have_first_q <= 1'b0;
			end_pend_q   <= 1'b0;
			emit_cur_q   <= 1'b0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			out_end_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
				out_end_q   <= state_q == CS_END;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				CS_IDLE: begin
					if (in_ctl.valid) begin
						if (in_ctl.end_mark) begin
							end_pend_q <= have_first_q;
						end else begin
							have_first_q <= 1'b1;
						end
					end
				end
				CS_EDGE: emit_cur_q <= !ip && iq;
				CS_EMIT: begin
					if (full || out_free) begin
						emit_cur_q <= 1'b0;
					end
					if (!full && out_free) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				CS_END: begin
					if (out_free) begin
						have_first_q <= 1'b0;
						end_pend_q   <= 1'b0;
						cnt_q        <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_x_q <= emit_x_q;
			out_y_q <= emit_y_q;
		end
		unique case (state_q)
			CS_IDLE: begin
				if (in_ctl.valid) begin
					if (in_ctl.end_mark) begin
						cur_x_q <= first_x_q;
						cur_y_q <= first_y_q;
					end else if (!have_first_q) begin
						first_x_q <= in_x;
						first_y_q <= in_y;
						prev_x_q  <= in_x;
						prev_y_q  <= in_y;
					end else begin
						cur_x_q <= in_x;
						cur_y_q <= in_y;
					end
				end
			end
			CS_EDGE: begin
				emit_x_q <= cur_x_q;
				emit_y_q <= cur_y_q;
			end
			CS_MUL: begin
				div_q  <= prod_w;
				dmag_q <= den_mag;
				neg_q  <= num_w[DW-1] ^ off_w[DW-1] ^ den_w[DW-1];
				o0_q   <= p_o;
				rem_q  <= '0;
				quo_q  <= '0;
				k_q    <= KW'(PW);
			end
			CS_DIV: begin
				rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
				quo_q <= {quo_q[DW-2:0], ge};
				div_q <= {div_q[PW-2:0], 1'b0};
				k_q   <= k_q - KW'(1);
			end
			CS_FIX: begin
				emit_x_q <= use_y ? fix_c : bound;
				emit_y_q <= use_y ? bound : fix_c;
			end
			CS_EMIT: begin
				if ((full || out_free) && emit_cur_q) begin
					emit_x_q <= cur_x_q;
					emit_y_q <= cur_y_q;
				end
			end
			CS_NEXT: begin
				prev_x_q <= cur_x_q;
				prev_y_q <= cur_y_q;
			end
			default: ;
		endcase
	end

	assign out_ctl.valid    = out_valid_q;
	assign out_ctl.end_mark = out_end_q;
	assign out_x            = out_x_q;
	assign out_y            = out_y_q;

endmodule

>>> rtl/core/polygon_rect_clipper.sv
// Rectangular-window polygon clipper.
// Input channel: one polygon vertex per transfer (in_valid/in_stall); the transfer
// with final_vertex set closes the polygon to its first vertex and starts clipping.
// While vertices load, in_stall stays low and a vertex is taken every cycle.
// Clipping then runs in a row of four cells (left, top, right, bottom), each
// taking the vertex stream of its left neighbor and passing its clipped stream on.
// The stored polygon is fed by reading each vertex and then sending it to the
// first cell. A cell finds the crossing on an edge that crosses its boundary
// with its bit-serial divider, and also emits the edge's end when the edge enters
// the window; the four cells overlap their work.
// Output channel: one clipped vertex per transfer (out_valid/out_stall), the last
// one marked by last_of_polygon, each read from the result store and then shown. A polygon
// that leaves nothing in the window gives one transfer with empty_polygon set.
// A stalled result holds steady until taken; input stays stalled from the final
// vertex until the last result transfer, so one polygon is in flight at a time.
// Reset sets the window to 50..200 on both axes and clears all counts and flags;
// the vertex stores need no clearing. Configuration writes (cfg_we) are taken
// at any edge and belong in idle time between polygons.
`include "polygon_rect_clipper_macros.svh"

module polygon_rect_clipper import prc_pkg::*; #(
	parameter int MAX_IN_VERTICES  = 16,
	parameter int MAX_OUT_VERTICES = 64,
	parameter int COORD_BITS       = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [COORD_BITS-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] vertex_x,
	input  logic signed [COORD_BITS-1:0] vertex_y,
	input  logic                         final_vertex,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] clipped_x,
	output logic signed [COORD_BITS-1:0] clipped_y,
	output logic                         last_of_polygon,
	output logic                         empty_polygon,
	output logic                         overflowed
);

	localparam int IN_AW  = $clog2(MAX_IN_VERTICES);
	localparam int LD_W   = $clog2(MAX_IN_VERTICES + 1);
	localparam int OUT_AW = $clog2(MAX_OUT_VERTICES);
	localparam int OUT_CW = $clog2(MAX_OUT_VERTICES + 1);

	top_state_t state_q, state_d;

	// Window registers.
	logic signed [COORD_BITS-1:0] win_x_min_q, win_x_max_q, win_y_min_q, win_y_max_q;

	logic [LD_W-1:0]   loaded_count_q, feed_idx_q;
	logic [OUT_CW-1:0] out_cnt_q, out_idx_q;
	logic              overflow_seen_q;

	// Vertex stores: the loaded polygon and the final clipped polygon.
	logic [2*COORD_BITS-1:0] in_mem  [MAX_IN_VERTICES];
	logic [2*COORD_BITS-1:0] out_mem [MAX_OUT_VERTICES];
	logic signed [COORD_BITS-1:0] feed_x_q, feed_y_q, rd_x_q, rd_y_q;

	// Links between the cells: link 0 is the feed, link NUM_SIDES the sink.
	link_ctl_t                    lk_ctl   [NUM_SIDES+1];
	logic signed [COORD_BITS-1:0] lk_x     [NUM_SIDES+1];
	logic signed [COORD_BITS-1:0] lk_y     [NUM_SIDES+1];
	logic                         lk_ready [NUM_SIDES+1];
	logic [NUM_SIDES-1:0]         cell_drop;
	logic signed [COORD_BITS-1:0] side_bound [NUM_SIDES];

	logic in_xfer, out_xfer, sink_take, out_last;

	assign side_bound[0] = win_x_min_q;
	assign side_bound[1] = win_y_min_q;
	assign side_bound[2] = win_x_max_q;
	assign side_bound[3] = win_y_max_q;

	assign lk_ctl[0].valid    = state_q == ST_FEED_SEND || state_q == ST_FEED_END;
	assign lk_ctl[0].end_mark = state_q == ST_FEED_END;
	assign lk_x[0]            = feed_x_q;
	assign lk_y[0]            = feed_y_q;

	for (genvar g = 0; g < NUM_SIDES; g++) begin : g_cell
		prc_cell #(
			.COORD_BITS (COORD_BITS),
			.MAX_OUT    (MAX_OUT_VERTICES)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.use_y     (SIDE_USE_Y[g]),
			.upper     (SIDE_UPPER[g]),
			.bound     (side_bound[g]),
			.in_ctl    (lk_ctl[g]),
			.in_x      (lk_x[g]),
			.in_y      (lk_y[g]),
			.in_ready  (lk_ready[g]),
			.out_ctl   (lk_ctl[g+1]),
			.out_x     (lk_x[g+1]),
			.out_y     (lk_y[g+1]),
			.out_ready (lk_ready[g+1]),
			.drop      (cell_drop[g])
		);
	end

	// The sink listens while the polygon is fed and while the cells finish.
	assign lk_ready[NUM_SIDES] = state_q == ST_FEED_RD || state_q == ST_FEED_SEND ||
		state_q == ST_FEED_END || state_q == ST_WAIT;
	assign sink_take = lk_ready[NUM_SIDES] && lk_ctl[NUM_SIDES].valid;

	assign in_stall  = state_q != ST_LOAD;
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = state_q == ST_OUT_SHOW || state_q == ST_OUT_EMPTY;
	assign out_xfer  = out_valid && !out_stall;
	assign out_last  = out_idx_q + OUT_CW'(1) == out_cnt_q;

	assign clipped_x       = state_q == ST_OUT_SHOW ? rd_x_q : '0;
	assign clipped_y       = state_q == ST_OUT_SHOW ? rd_y_q : '0;
	assign last_of_polygon = state_q == ST_OUT_EMPTY || (state_q == ST_OUT_SHOW && out_last);
	assign empty_polygon   = state_q == ST_OUT_EMPTY;
	assign overflowed      = overflow_seen_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_xfer && final_vertex) begin
					state_d = ST_FEED_RD;
				end
			end
			ST_FEED_RD: state_d = ST_FEED_SEND;
			ST_FEED_SEND: begin
				if (lk_ready[0]) begin
					state_d = (feed_idx_q + LD_W'(1) == loaded_count_q) ? ST_FEED_END
						: ST_FEED_RD;
				end
			end
			ST_FEED_END: begin
				if (lk_ready[0]) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (sink_take && lk_ctl[NUM_SIDES].end_mark) begin
					state_d = (out_cnt_q == '0) ? ST_OUT_EMPTY : ST_OUT_RD;
				end
			end
			ST_OUT_RD: state_d = ST_OUT_SHOW;
			ST_OUT_SHOW: begin
				if (out_xfer) begin
					state_d = out_last ? ST_LOAD : ST_OUT_RD;
				end
			end
			ST_OUT_EMPTY: begin
				if (out_xfer) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_LOAD;
			win_x_min_q     <= COORD_BITS'(WIN_RESET_LOW);
			win_x_max_q     <= COORD_BITS'(WIN_RESET_HIGH);
			win_y_min_q     <= COORD_BITS'(WIN_RESET_LOW);
			win_y_max_q     <= COORD_BITS'(WIN_RESET_HIGH);
			loaded_count_q  <= '0;
			feed_idx_q      <= '0;
			out_cnt_q       <= '0;
			out_idx_q       <= '0;
			overflow_seen_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_index)
					REG_X_MIN: win_x_min_q <= cfg_data;
					REG_X_MAX: win_x_max_q <= cfg_data;
					REG_Y_MIN: win_y_min_q <= cfg_data;
					REG_Y_MAX: win_y_max_q <= cfg_data;
					default: ;
				endcase
			end

			if (in_xfer) begin
				if (loaded_count_q != LD_W'(MAX_IN_VERTICES)) begin
					loaded_count_q <= loaded_count_q + LD_W'(1);
				end else begin
					overflow_seen_q <= 1'b1;
				end
				feed_idx_q <= '0;
			end

			if (|cell_drop) begin
				overflow_seen_q <= 1'b1;
			end

			if (state_q == ST_FEED_SEND && lk_ready[0]) begin
				feed_idx_q <= feed_idx_q + LD_W'(1);
			end

			if (sink_take && !lk_ctl[NUM_SIDES].end_mark) begin
				out_cnt_q <= out_cnt_q + OUT_CW'(1);
			end
			if (sink_take && lk_ctl[NUM_SIDES].end_mark) begin
				out_idx_q <= '0;
			end

			if (state_q == ST_OUT_SHOW && out_xfer && !out_last) begin
				out_idx_q <= out_idx_q + OUT_CW'(1);
			end

			// The polygon is done once its last result is taken.
			if (out_xfer && last_of_polygon) begin
				loaded_count_q  <= '0;
				out_cnt_q       <= '0;
				overflow_seen_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && loaded_count_q != LD_W'(MAX_IN_VERTICES)) begin
			in_mem[loaded_count_q[IN_AW-1:0]] <= {vertex_x, vertex_y};
		end
		if (state_q == ST_FEED_RD) begin
			{feed_x_q, feed_y_q} <= in_mem[feed_idx_q[IN_AW-1:0]];
		end
		if (sink_take && !lk_ctl[NUM_SIDES].end_mark) begin
			out_mem[out_cnt_q[OUT_AW-1:0]] <= {lk_x[NUM_SIDES], lk_y[NUM_SIDES]};
		end
		if (state_q == ST_OUT_RD) begin
			{rd_x_q, rd_y_q} <= out_mem[out_idx_q[OUT_AW-1:0]];
		end
	end

	// Delivering the last result leaves the block clean for the next polygon.
	`PRC_ASSERT_NEXT(a_clear_after_last, clk, arst_n, out_xfer && last_of_polygon,
		loaded_count_q == '0 && !overflow_seen_q && state_q == ST_LOAD)
	// An empty result is always a single, final transfer.
	`PRC_ASSERT_NOW(a_empty_is_last, clk, arst_n, empty_polygon, last_of_polygon && out_valid)
	// A vertex arriving at a full input store is recorded as an overflow.
	`PRC_ASSERT_NEXT(a_input_overflow, clk, arst_n,
		in_xfer && loaded_count_q == LD_W'(MAX_IN_VERTICES), overflow_seen_q)
	// The last cell caps its stream, so the result store never overruns.
	`PRC_ASSERT_NOW(a_out_count_bound, clk, arst_n, sink_take,
		out_cnt_q <= OUT_CW'(MAX_OUT_VERTICES))

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the rectangular-window polygon clipper.
// The driver sends vertices from a queue that the initial block fills. When a
// vertex is taken, a local clipping model works out the results that the block
// must return. The monitor compares each result transfer with the oldest
// expected vertex. The window registers are rewritten only between polygons,
// and only once the block has gone quiet.
module tb_top;
	import prc_pkg::*;

	localparam int CB = 16;
	localparam int IN_DEPTH = 16;
	localparam int OUT_DEPTH = 64;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic fin;
	} vertex_t;

	typedef struct {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic last;
		logic empty;
		logic ovf;
	} clip_vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = REG_X_MIN;
	logic [CB-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CB-1:0] vertex_x = '0;
	logic signed [CB-1:0] vertex_y = '0;
	logic final_vertex = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [CB-1:0] clipped_x;
	logic signed [CB-1:0] clipped_y;
	logic last_of_polygon;
	logic empty_polygon;
	logic overflowed;

	polygon_rect_clipper DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .final_vertex(final_vertex),
		.out_valid(out_valid), .out_stall(out_stall),
		.clipped_x(clipped_x), .clipped_y(clipped_y),
		.last_of_polygon(last_of_polygon), .empty_polygon(empty_polygon),
		.overflowed(overflowed)
	);

	always #10 clk = ~clk;

	// Window as the model sees it: bounds indexed by side (left, top, right, bottom).
	longint win_bound [NUM_SIDES];

	// Polygon being collected by the model.
	longint poly_x [OUT_DEPTH];
	longint poly_y [OUT_DEPTH];
	int poly_len;
	bit poly_ovf;

	vertex_t pending_vertices[$];
	clip_vertex_t expected_vertices[$];
	vertex_t shown;

	int failures;
	int vertices_sent;
	int results_seen;
	int polygons_sent;
	int empty_seen;
	int ovf_seen;
	int cycles;
	bit calm;

	// Whether a point is on the kept side of one boundary.
	function automatic bit on_kept_side(longint px, longint py, int side);
		longint c;
		c = SIDE_USE_Y[side] ? py : px;
		return SIDE_UPPER[side] ? (c <= win_bound[side]) : (c >= win_bound[side]);
	endfunction

	// o0 + num*off/den, with the exact result truncated toward zero.
	function automatic longint crossing_coord(longint o0, longint num, longint off,
			longint den);
		longint prod, q, r, base;
		bit neg;
		if (num == 0 || off == 0)
			return o0;
		prod = num * off;
		neg = (prod < 0) != (den < 0);
		if (prod < 0)
			prod = -prod;
		if (den < 0)
			den = -den;
		q = prod / den;
		r = prod % den;
		base = neg ? o0 - q : o0 + q;
		if (r != 0) begin
			if (!neg && base < 0)
				base += 1;
			else if (neg && base > 0)
				base -= 1;
		end
		return base;
	endfunction

	// Takes one accepted vertex; on the closing vertex, clips the stored polygon
	// against the four boundaries in turn and queues the resulting vertices.
	task automatic clip_accepted_vertex(vertex_t v);
		longint sx [OUT_DEPTH];
		longint sy [OUT_DEPTH];
		longint dx [OUT_DEPTH];
		longint dy [OUT_DEPTH];
		longint cx, cy, px, py, qx, qy;
		int n, m, side, i;
		bit ip, iq;
		clip_vertex_t r;
		if (poly_len < IN_DEPTH) begin
			poly_x[poly_len] = v.x;
			poly_y[poly_len] = v.y;
			poly_len++;
		end else begin
			poly_ovf = 1'b1;
		end
		if (!v.fin)
			return;
		n = poly_len;
		for (i = 0; i < n; i++) begin
			sx[i] = poly_x[i];
			sy[i] = poly_y[i];
		end
		for (side = 0; side < NUM_SIDES; side++) begin
			m = 0;
			for (i = 0; i < n; i++) begin
				px = sx[i];
				py = sy[i];
				qx = sx[(i + 1) % n];
				qy = sy[(i + 1) % n];
				ip = on_kept_side(px, py, side);
				iq = on_kept_side(qx, qy, side);
				if (ip != iq) begin
					if (SIDE_USE_Y[side]) begin
						cy = win_bound[side];
						cx = crossing_coord(px, qx - px, cy - py, qy - py);
					end else begin
						cx = win_bound[side];
						cy = crossing_coord(py, qy - py, cx - px, qx - px);
					end
					if (m < OUT_DEPTH) begin
						dx[m] = cx;
						dy[m] = cy;
						m++;
					end else begin
						poly_ovf = 1'b1;
					end
				end
				if (iq) begin
					if (m < OUT_DEPTH) begin
						dx[m] = qx;
						dy[m] = qy;
						m++;
					end else begin
						poly_ovf = 1'b1;
					end
				end
			end
			n = m;
			for (i = 0; i < n; i++) begin
				sx[i] = dx[i];
				sy[i] = dy[i];
			end
		end
		if (n == 0) begin
			r = '{x: '0, y: '0, last: 1'b1, empty: 1'b1, ovf: poly_ovf};
			expected_vertices.push_back(r);
		end
		for (i = 0; i < n; i++) begin
			r.x = sx[i][CB-1:0];
			r.y = sy[i][CB-1:0];
			r.last = (i == n - 1);
			r.empty = 1'b0;
			r.ovf = poly_ovf;
			expected_vertices.push_back(r);
		end
		poly_len = 0;
		poly_ovf = 1'b0;
		polygons_sent++;
	endtask

	// Driver. A shown vertex stays put while stalled; otherwise the next one
	// is shown, or the channel idles at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				clip_accepted_vertex(shown);
				vertices_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_vertices.size() > 0 && (calm || $urandom_range(99) >= 33)) begin
					shown = pending_vertices.pop_front();
					vertex_x <= shown.x;
					vertex_y <= shown.y;
					final_vertex <= shown.fin;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Coordinates of an empty-polygon result carry no meaning, so
	// only the flags are compared for it.
	always @(posedge clk or negedge arst_n) begin
		clip_vertex_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_vertices.size() == 0) begin
					$error("unexpected result transfer x=%0d y=%0d", clipped_x, clipped_y);
					failures++;
				end else begin
					e = expected_vertices.pop_front();
					if (e.empty)
						empty_seen++;
					if (e.ovf)
						ovf_seen++;
					if (!e.empty && clipped_x !== e.x) begin
						$error("clipped_x expected %0d got %0d", e.x, clipped_x);
						failures++;
					end
					if (!e.empty && clipped_y !== e.y) begin
						$error("clipped_y expected %0d got %0d", e.y, clipped_y);
						failures++;
					end
					if (last_of_polygon !== e.last) begin
						$error("last_of_polygon expected %0b got %0b", e.last, last_of_polygon);
						failures++;
					end
					if (empty_polygon !== e.empty) begin
						$error("empty_polygon expected %0b got %0b", e.empty, empty_polygon);
						failures++;
					end
					if (overflowed !== e.ovf) begin
						$error("overflowed expected %0b got %0b", e.ovf, overflowed);
						failures++;
					end
				end
			end
			out_stall <= calm ? 1'b0 : ($urandom_range(99) < 33);
		end
	end

	// Cycle counter with a hard limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d results still expected", expected_vertices.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic signed [CB-1:0] clamp_coord(longint v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return v[CB-1:0];
	endfunction

	task automatic add_vertex(longint x, longint y, bit fin);
		vertex_t v;
		v.x = clamp_coord(x);
		v.y = clamp_coord(y);
		v.fin = fin;
		pending_vertices.push_back(v);
	endtask

	// One random coordinate: mostly near the window span, sometimes anywhere.
	function automatic longint random_coord(longint lo, longint hi, bit wide);
		longint a, b;
		if (wide || lo > hi)
			return $signed(16'($urandom));
		a = lo - 60;
		b = hi + 60;
		if (b - a > 60000)
			return $signed(16'($urandom));
		return a + $urandom_range(int'(b - a));
	endfunction

	task automatic add_random_polygon(int n, bit wide);
		int i;
		for (i = 0; i < n; i++)
			add_vertex(random_coord(win_bound[0], win_bound[2], wide),
				random_coord(win_bound[1], win_bound[3], wide), i == n - 1);
	endtask

	// Random polygon size: mostly small, now and then one that overfills the store.
	function automatic int random_size();
		int pick;
		pick = $urandom_range(99);
		if (pick < 5)
			return $urandom_range(2, 1);
		if (pick < 13)
			return $urandom_range(20, 17);
		return $urandom_range(9, 3);
	endfunction

	task automatic write_window(logic [CFG_IDX_BITS-1:0] idx, longint value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CB-1:0];
		if (idx < NUM_SIDES) begin
			// Register order is xmin, xmax, ymin, ymax; sides are left, top, right, bottom.
			case (idx)
				REG_X_MIN: win_bound[0] = $signed(value[CB-1:0]);
				REG_Y_MIN: win_bound[1] = $signed(value[CB-1:0]);
				REG_X_MAX: win_bound[2] = $signed(value[CB-1:0]);
				default:   win_bound[3] = $signed(value[CB-1:0]);
			endcase
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_window(longint xmin, longint xmax, longint ymin, longint ymax);
		write_window(REG_X_MIN, xmin);
		write_window(REG_X_MAX, xmax);
		write_window(REG_Y_MIN, ymin);
		write_window(REG_Y_MAX, ymax);
	endtask

	// Holds off until every queued vertex is taken and every result is back,
	// then lets the block settle.
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (pending_vertices.size() > 0 || in_valid || expected_vertices.size() > 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic random_phase(int count, bit wide);
		int target;
		target = vertices_sent + count;
		while (vertices_sent + pending_vertices.size() < target) begin
			add_random_polygon(random_size(), wide && $urandom_range(1));
			// Sometimes hold the next polygon back until this one is fully answered.
			if ($urandom_range(3) == 0)
				wait_quiet();
		end
		wait_quiet();
	endtask

	initial begin
		int i;
		win_bound[0] = WIN_RESET_LOW;
		win_bound[1] = WIN_RESET_LOW;
		win_bound[2] = WIN_RESET_HIGH;
		win_bound[3] = WIN_RESET_HIGH;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed polygons against the reset window.
		// Square wholly inside.
		add_vertex(60, 60, 0); add_vertex(190, 60, 0);
		add_vertex(190, 190, 0); add_vertex(60, 190, 1);
		// Triangle wholly outside, at the coordinate extremes.
		add_vertex(-32768, -32768, 0); add_vertex(32767, -32768, 0);
		add_vertex(-32768, 32767, 1);
		// Square that crosses all four boundaries, and one covering the window.
		add_vertex(0, 125, 0); add_vertex(125, 0, 0);
		add_vertex(250, 125, 0); add_vertex(125, 250, 1);
		add_vertex(-32768, -32768, 0); add_vertex(32767, -32768, 0);
		add_vertex(32767, 32767, 0); add_vertex(-32768, 32767, 1);
		// Lone vertex inside, and a sharp edge needing truncated crossings.
		add_vertex(100, 100, 1);
		add_vertex(13, 77, 0); add_vertex(211, 103, 0); add_vertex(97, -5, 1);
		// Eighteen vertices: the input store overflows.
		for (i = 0; i < 18; i++)
			add_vertex(60 + 7 * i, (i % 2) ? 70 : 180, i == 17);
		wait_quiet();

		random_phase(30, 1'b0);

		// Widest window, with an ignored register index written as well.
		set_window(-32768, 32767, -32768, 32767);
		write_window(3'd5, 1234);
		random_phase(20, 1'b1);

		// Inverted window usually leaves nothing.
		set_window(300, -300, 300, -300);
		random_phase(15, 1'b0);

		// Narrowest window, one point, with no idling on either side.
		set_window(32767, 32767, -32768, -32768);
		calm = 1'b1;
		add_vertex(32767, -32768, 1);
		random_phase(20, 1'b1);
		calm = 1'b0;

		// A few random windows.
		repeat (3) begin
			set_window(-1000 + $urandom_range(900), $urandom_range(1000),
				-1000 + $urandom_range(900), $urandom_range(1000));
			random_phase(15, 1'b0);
		end

		repeat (200) @(negedge clk);
		$display("Clipped %0d polygons from %0d vertices into %0d result vertices,",
			polygons_sent, vertices_sent, results_seen);
		$display("%0d of them empty and %0d flagged overflow, over seven windows.",
			empty_seen, ovf_seen);
		if (failures == 0 && expected_vertices.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> polygon_rect_clipper.f
+incdir+rtl/core
rtl/core/prc_pkg.sv
rtl/core/prc_cell.sv
rtl/core/polygon_rect_clipper.sv
tb/tb_top.sv
